/* src/socks5_method_and_userpass_auth_unit_assert.svh */
// Assertion macros for the SOCKS5 negotiation unit.
// Used by socks5_method_and_userpass_auth_unit; needs clock and reset in scope.
`ifndef SOCKS5_METHOD_AND_USERPASS_AUTH_UNIT_ASSERT_SVH
`define SOCKS5_METHOD_AND_USERPASS_AUTH_UNIT_ASSERT_SVH

// Same-cycle implication
`define S5A_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define S5A_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/s5auth_pkg.sv */
// Types and constants for the SOCKS5 method and user/password negotiation unit.
// No dependencies.
`default_nettype none

package s5auth_pkg;

   // Protocol constants
   localparam logic [7:0] PROTO_V5        = 8'h05;
   localparam logic [7:0] METHOD_NONE     = 8'h00;
   localparam logic [7:0] METHOD_PASSWORD = 8'h02;
   localparam logic [7:0] METHOD_REFUSED  = 8'hFF;
   localparam logic [7:0] AUTH_VER        = 8'h01;
   localparam logic [7:0] AUTH_OK         = 8'h00;
   localparam logic [7:0] AUTH_FAIL       = 8'h01;

   // Session outcome codes
   localparam logic [1:0] OUT_CONT   = 2'd0;
   localparam logic [1:0] OUT_ACCEPT = 2'd1;
   localparam logic [1:0] OUT_REJECT = 2'd2;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_AUTH_REQUIRED    = 3'd0;
   localparam logic [2:0] REG_USER_NAME_BYTES  = 3'd1;
   localparam logic [2:0] REG_USER_NAME_LENGTH = 3'd2;
   localparam logic [2:0] REG_PASS_WORD_BYTES  = 3'd3;
   localparam logic [2:0] REG_PASS_WORD_LENGTH = 3'd4;

   // Negotiation phases
   typedef enum logic [3:0] {
      PH_VER     = 4'd0,
      PH_NMETH   = 4'd1,
      PH_METHODS = 4'd2,
      PH_AVER    = 4'd3,
      PH_ULEN    = 4'd4,
      PH_UNAME   = 4'd5,
      PH_PLEN    = 4'd6,
      PH_PASS    = 4'd7,
      PH_DONE    = 4'd8
   } phase_type;

   // Input item
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       new_session;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic       has_byte;
      logic [7:0] reply_byte;
      logic       last_of_run;
      logic [1:0] outcome;
   } rsp_item_type;

endpackage

`default_nettype wire

/* src/socks5_method_and_userpass_auth_unit.sv */
// The first result of an item is valid the cycle after the item is accepted; a second
// result follows once the first is taken. One item per cycle while the result side does
// not stall; an item with two results holds the input until its second result is taken.
// Bytes after a finished session are taken with no result. Synchronous active-high reset
// clears the session state, the result buffer flags and the registers to their defaults.
// Depends on s5auth_pkg and socks5_method_and_userpass_auth_unit_assert.svh.
`default_nettype none
`include "socks5_method_and_userpass_auth_unit_assert.svh"

module socks5_method_and_userpass_auth_unit #(
   parameter int CRED_BYTES = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   // input channel
   input  wire                        req_valid,
   output logic                       req_stall,
   input  s5auth_pkg::req_item_type   req_payload,
   // result channel
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output s5auth_pkg::rsp_item_type   rsp_payload,
   // configuration port
   input  wire                        psel,
   input  wire                        penable,
   input  wire                        pwrite,
   input  wire  [5:0]                 paddr,
   input  wire  [63:0]                pwdata,
   output logic [63:0]                prdata,
   output logic                       pready
);

   import s5auth_pkg::*;

   localparam int CRED_W = 8 * CRED_BYTES;

   // Configuration registers
   logic              auth_required_ff;
   logic [CRED_W-1:0] user_bytes_ff;
   logic [3:0]        user_len_ff;
   logic [CRED_W-1:0] pass_bytes_ff;
   logic [3:0]        pass_len_ff;

   // Session state
   phase_type   phase_ff, phase_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic        method_found_ff, method_found_in;
   logic [7:0]  field_pos_ff, field_pos_in;
   logic        user_match_ff, user_match_in;
   logic        pass_match_ff, pass_match_in;

   // Result buffer: slot0 is presented, slot1 holds the second result of a pair
   rsp_item_type slot0_ff, slot1_ff;
   logic         rsp_valid_ff, slot1_valid_ff;

   // Per-item combinational results
   rsp_item_type res0, res1;
   logic [1:0]   nres;

   logic       in_take, out_take, cfg_wr;
   logic [2:0] reg_idx;
   logic [7:0] b;
   phase_type  s_phase;
   logic [7:0] s_remaining, s_field_pos, rem_dec;
   logic       s_method_found, s_user_match, s_pass_match;
   logic [7:0] wanted;
   logic       user_byte_ok, pass_byte_ok;

   // Handshakes
   assign pready    = 1'b1;
   assign cfg_wr    = psel & penable & pwrite & pready;
   assign reg_idx   = paddr[5:3];
   assign out_take  = rsp_valid_ff & ~rsp_stall;
   assign req_stall = rsp_valid_ff & ~(out_take & ~slot1_valid_ff);
   assign in_take   = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = slot0_ff;

   // Register read-back
   always_comb begin
      case (reg_idx)
         REG_AUTH_REQUIRED:    prdata = {63'd0, auth_required_ff};
         REG_USER_NAME_BYTES:  prdata = 64'(user_bytes_ff);
         REG_USER_NAME_LENGTH: prdata = {60'd0, user_len_ff};
         REG_PASS_WORD_BYTES:  prdata = 64'(pass_bytes_ff);
         REG_PASS_WORD_LENGTH: prdata = {60'd0, pass_len_ff};
         default:              prdata = 64'd0;
      endcase
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         auth_required_ff <= 1'b0;
         user_bytes_ff    <= '0;
         user_len_ff      <= 4'd1;
         pass_bytes_ff    <= '0;
         pass_len_ff      <= 4'd1;
      end else if (cfg_wr) begin
         case (reg_idx)
            REG_AUTH_REQUIRED:    auth_required_ff <= pwdata[0];
            REG_USER_NAME_BYTES:  user_bytes_ff    <= pwdata[CRED_W-1:0];
            REG_USER_NAME_LENGTH: user_len_ff      <= pwdata[3:0];
            REG_PASS_WORD_BYTES:  pass_bytes_ff    <= pwdata[CRED_W-1:0];
            REG_PASS_WORD_LENGTH: pass_len_ff      <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Credential byte compare at the current field position (false past the stored bytes)
   always_comb begin
      user_byte_ok = 1'b0;
      pass_byte_ok = 1'b0;
      for (int k = 0; k < CRED_BYTES; k++) begin
         if (s_field_pos == 8'(k) && user_bytes_ff[8*k +: 8] == b) user_byte_ok = 1'b1;
         if (s_field_pos == 8'(k) && pass_bytes_ff[8*k +: 8] == b) pass_byte_ok = 1'b1;
      end
   end

   // Session state as seen by this item, cleared first on new_session
   always_comb begin
      b = req_payload.rx_byte;
      if (req_payload.new_session) begin
         s_phase        = PH_VER;
         s_remaining    = 8'd0;
         s_method_found = 1'b0;
         s_field_pos    = 8'd0;
         s_user_match   = 1'b1;
         s_pass_match   = 1'b1;
      end else begin
         s_phase        = phase_ff;
         s_remaining    = remaining_ff;
         s_method_found = method_found_ff;
         s_field_pos    = field_pos_ff;
         s_user_match   = user_match_ff;
         s_pass_match   = pass_match_ff;
      end
      rem_dec = s_remaining - 8'd1;
      wanted  = auth_required_ff ? METHOD_PASSWORD : METHOD_NONE;
   end

   // Next state and results for one item
   always_comb begin
      phase_in        = s_phase;
      remaining_in    = s_remaining;
      method_found_in = s_method_found;
      field_pos_in    = s_field_pos;
      user_match_in   = s_user_match;
      pass_match_in   = s_pass_match;

      // default: one silent result, session continuing
      nres             = 2'd1;
      res0.has_byte    = 1'b0;
      res0.reply_byte  = 8'd0;
      res0.last_of_run = 1'b1;
      res0.outcome     = OUT_CONT;
      res1.has_byte    = 1'b1;
      res1.reply_byte  = 8'd0;
      res1.last_of_run = 1'b1;
      res1.outcome     = OUT_CONT;

      case (s_phase)
         PH_VER: begin
            if (b != PROTO_V5) begin
               phase_in     = PH_DONE;
               res0.outcome = OUT_REJECT;
            end else begin
               phase_in = PH_NMETH;
            end
         end
         PH_NMETH: begin
            if (b == 8'd0) begin
               phase_in     = PH_DONE;
               res0.outcome = OUT_REJECT;
            end else begin
               remaining_in    = b;
               method_found_in = 1'b0;
               phase_in        = PH_METHODS;
            end
         end
         PH_METHODS: begin
            if (b == wanted) method_found_in = 1'b1;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) begin
               // method list complete: version byte then chosen method
               nres             = 2'd2;
               res0.has_byte    = 1'b1;
               res0.reply_byte  = PROTO_V5;
               res0.last_of_run = 1'b0;
               if (!method_found_in) begin
                  phase_in        = PH_DONE;
                  res1.reply_byte = METHOD_REFUSED;
                  res1.outcome    = OUT_REJECT;
               end else if (!auth_required_ff) begin
                  phase_in        = PH_DONE;
                  res1.reply_byte = METHOD_NONE;
                  res1.outcome    = OUT_ACCEPT;
               end else begin
                  phase_in        = PH_AVER;
                  res1.reply_byte = METHOD_PASSWORD;
               end
            end
         end
         PH_AVER: begin
            if (b != AUTH_VER) begin
               phase_in     = PH_DONE;
               res0.outcome = OUT_REJECT;
            end else begin
               phase_in = PH_ULEN;
            end
         end
         PH_ULEN: begin
            if (b == 8'd0) begin
               phase_in     = PH_DONE;
               res0.outcome = OUT_REJECT;
            end else begin
               remaining_in  = b;
               field_pos_in  = 8'd0;
               user_match_in = (b == {4'd0, user_len_ff});
               phase_in      = PH_UNAME;
            end
         end
         PH_UNAME: begin
            if (!user_byte_ok) user_match_in = 1'b0;
            field_pos_in = s_field_pos + 8'd1;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) phase_in = PH_PLEN;
         end
         PH_PLEN: begin
            if (b == 8'd0) begin
               phase_in     = PH_DONE;
               res0.outcome = OUT_REJECT;
            end else begin
               remaining_in  = b;
               field_pos_in  = 8'd0;
               pass_match_in = (b == {4'd0, pass_len_ff});
               phase_in      = PH_PASS;
            end
         end
         PH_PASS: begin
            if (!pass_byte_ok) pass_match_in = 1'b0;
            field_pos_in = s_field_pos + 8'd1;
            remaining_in = rem_dec;
            if (rem_dec == 8'd0) begin
               // credentials complete: auth version then status
               phase_in         = PH_DONE;
               nres             = 2'd2;
               res0.has_byte    = 1'b1;
               res0.reply_byte  = AUTH_VER;
               res0.last_of_run = 1'b0;
               if (s_user_match && pass_match_in) begin
                  res1.reply_byte = AUTH_OK;
                  res1.outcome    = OUT_ACCEPT;
               end else begin
                  res1.reply_byte = AUTH_FAIL;
                  res1.outcome    = OUT_REJECT;
               end
            end
         end
         default: begin
            // session finished: byte ignored
            phase_in = PH_DONE;
            nres     = 2'd0;
         end
      endcase
   end

   // Session state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_VER;
         remaining_ff    <= 8'd0;
         method_found_ff <= 1'b0;
         field_pos_ff    <= 8'd0;
         user_match_ff   <= 1'b1;
         pass_match_ff   <= 1'b1;
      end else if (in_take) begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         method_found_ff <= method_found_in;
         field_pos_ff    <= field_pos_in;
         user_match_ff   <= user_match_in;
         pass_match_ff   <= pass_match_in;
      end
   end

   // Result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         slot1_valid_ff <= 1'b0;
      end else if (in_take) begin
         rsp_valid_ff   <= (nres != 2'd0);
         slot1_valid_ff <= (nres == 2'd2);
      end else if (out_take) begin
         rsp_valid_ff   <= slot1_valid_ff;
         slot1_valid_ff <= 1'b0;
      end
   end

   // Result buffer payload
   always_ff @(posedge clock) begin
      if (in_take) begin
         slot0_ff <= res0;
         slot1_ff <= res1;
      end else if (out_take && slot1_valid_ff) begin
         slot0_ff <= slot1_ff;
      end
   end

   // Checks
   `S5A_ASSERT_IMP(a_slot1_behind_slot0, slot1_valid_ff, rsp_valid_ff,
      "second result held without a first")
   `S5A_ASSERT_IMP(a_pair_order, slot1_valid_ff,
      slot1_ff.last_of_run && !slot0_ff.last_of_run && slot0_ff.has_byte,
      "reply pair out of order")
   `S5A_ASSERT_IMP(a_silent_is_last, rsp_valid_ff && !slot0_ff.has_byte,
      slot0_ff.last_of_run && slot0_ff.outcome != OUT_ACCEPT,
      "silent result not final or claims acceptance")
   `S5A_ASSERT_NXT(a_done_sticks,
      in_take && phase_ff == PH_DONE && !req_payload.new_session,
      phase_ff == PH_DONE && !rsp_valid_ff,
      "finished session restarted or answered")

endmodule

`default_nettype wire

/* tb/socks5_auth_checker.sv */
// Checker for the SOCKS5 method and user/password negotiation unit: follows the
// register writes, predicts the replies of every accepted item and compares them.
// Depends on s5auth_pkg.
module socks5_auth_checker #(
   parameter int CRED_BYTES = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   // input channel
   input  wire                        req_valid,
   input  wire                        req_stall,
   input  s5auth_pkg::req_item_type   req_payload,
   // result channel
   input  wire                        rsp_valid,
   input  wire                        rsp_stall,
   input  s5auth_pkg::rsp_item_type   rsp_payload,
   // configuration port
   input  wire                        psel,
   input  wire                        penable,
   input  wire                        pwrite,
   input  wire                        pready,
   input  wire  [5:0]                 paddr,
   input  wire  [63:0]                pwdata,
   // to the testbench top
   output int                         fail_count,
   output int                         pending_results,
   output int                         accepted_items
);
   timeunit 1ns;
   timeprecision 1ps;
   import s5auth_pkg::*;

   // Register copies
   logic         want_userpass;
   logic [63:0]  name_cfg;
   logic [3:0]   name_len_cfg;
   logic [63:0]  word_cfg;
   logic [3:0]   word_len_cfg;

   // Session state
   phase_type    sess_phase;
   logic [7:0]   bytes_left;
   logic         method_seen;
   logic [7:0]   cred_pos;
   logic         name_ok;
   logic         word_ok;

   // Replies predicted but not yet seen on the result channel
   rsp_item_type expected_replies[$];

   function automatic rsp_item_type make_reply(logic has, logic [7:0] b, logic last,
                                                logic [1:0] oc);
      rsp_item_type r;
      r.has_byte    = has;
      r.reply_byte  = b;
      r.last_of_run = last;
      r.outcome     = oc;
      return r;
   endfunction

   // Credential byte compare; positions past the store never match
   function automatic logic cred_hit(logic [63:0] cred, logic [7:0] pos, logic [7:0] b);
      if (pos >= CRED_BYTES) return 1'b0;
      return cred[8*pos +: 8] == b;
   endfunction

   task automatic clear_session();
      sess_phase  = PH_VER;
      bytes_left  = 8'd0;
      method_seen = 1'b0;
      cred_pos    = 8'd0;
      name_ok     = 1'b1;
      word_ok     = 1'b1;
   endtask

   task automatic add_silent(logic [1:0] oc);
      expected_replies.push_back(make_reply(1'b0, 8'h00, 1'b1, oc));
   endtask

   task automatic refuse();
      sess_phase = PH_DONE;
      add_silent(OUT_REJECT);
   endtask

   task automatic add_pair(logic [7:0] first, logic [7:0] second, logic [1:0] oc);
      expected_replies.push_back(make_reply(1'b1, first, 1'b0, OUT_CONT));
      expected_replies.push_back(make_reply(1'b1, second, 1'b1, oc));
   endtask

   // Advance the negotiation by one received byte
   task automatic negotiate(req_item_type it);
      logic [7:0] b;
      logic [7:0] wanted;
      b = it.rx_byte;
      if (it.new_session) clear_session();
      case (sess_phase)
         PH_VER: begin
            if (b != PROTO_V5) refuse();
            else begin
               sess_phase = PH_NMETH;
               add_silent(OUT_CONT);
            end
         end
         PH_NMETH: begin
            if (b == 8'd0) refuse();
            else begin
               bytes_left  = b;
               method_seen = 1'b0;
               sess_phase  = PH_METHODS;
               add_silent(OUT_CONT);
            end
         end
         PH_METHODS: begin
            wanted = want_userpass ? METHOD_PASSWORD : METHOD_NONE;
            if (b == wanted) method_seen = 1'b1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left != 8'd0) add_silent(OUT_CONT);
            else if (!method_seen) begin
               sess_phase = PH_DONE;
               add_pair(PROTO_V5, METHOD_REFUSED, OUT_REJECT);
            end else if (!want_userpass) begin
               sess_phase = PH_DONE;
               add_pair(PROTO_V5, METHOD_NONE, OUT_ACCEPT);
            end else begin
               sess_phase = PH_AVER;
               add_pair(PROTO_V5, METHOD_PASSWORD, OUT_CONT);
            end
         end
         PH_AVER: begin
            if (b != AUTH_VER) refuse();
            else begin
               sess_phase = PH_ULEN;
               add_silent(OUT_CONT);
            end
         end
         PH_ULEN: begin
            if (b == 8'd0) refuse();
            else begin
               bytes_left = b;
               cred_pos   = 8'd0;
               name_ok    = (b == {4'd0, name_len_cfg});
               sess_phase = PH_UNAME;
               add_silent(OUT_CONT);
            end
         end
         PH_UNAME: begin
            if (!cred_hit(name_cfg, cred_pos, b)) name_ok = 1'b0;
            cred_pos   = cred_pos + 8'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) sess_phase = PH_PLEN;
            add_silent(OUT_CONT);
         end
         PH_PLEN: begin
            if (b == 8'd0) refuse();
            else begin
               bytes_left = b;
               cred_pos   = 8'd0;
               word_ok    = (b == {4'd0, word_len_cfg});
               sess_phase = PH_PASS;
               add_silent(OUT_CONT);
            end
         end
         PH_PASS: begin
            if (!cred_hit(word_cfg, cred_pos, b)) word_ok = 1'b0;
            cred_pos   = cred_pos + 8'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left != 8'd0) add_silent(OUT_CONT);
            else begin
               sess_phase = PH_DONE;
               if (name_ok && word_ok) add_pair(AUTH_VER, AUTH_OK, OUT_ACCEPT);
               else add_pair(AUTH_VER, AUTH_FAIL, OUT_REJECT);
            end
         end
         // finished session: byte is swallowed without a reply
         default: sess_phase = PH_DONE;
      endcase
   endtask

   // Per-cycle monitor: register writes, result compare, then prediction
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      int errs;
      errs = 0;
      if (reset) begin
         want_userpass = 1'b0;
         name_cfg      = '0;
         name_len_cfg  = 4'd1;
         word_cfg      = '0;
         word_len_cfg  = 4'd1;
         clear_session();
         expected_replies.delete();
         fail_count     <= 0;
         accepted_items <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               REG_AUTH_REQUIRED:    want_userpass = pwdata[0];
               REG_USER_NAME_BYTES:  name_cfg      = pwdata;
               REG_USER_NAME_LENGTH: name_len_cfg  = pwdata[3:0];
               REG_PASS_WORD_BYTES:  word_cfg      = pwdata;
               REG_PASS_WORD_LENGTH: word_len_cfg  = pwdata[3:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("result with none expected: has_byte %0d reply_byte %h last %0d outcome %0d",
                      rsp_payload.has_byte, rsp_payload.reply_byte,
                      rsp_payload.last_of_run, rsp_payload.outcome);
               errs++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_payload.has_byte !== want.has_byte) begin
                  $error("has_byte: expected %0d, got %0d", want.has_byte, rsp_payload.has_byte);
                  errs++;
               end
               if (rsp_payload.reply_byte !== want.reply_byte) begin
                  $error("reply_byte: expected %h, got %h", want.reply_byte,
                         rsp_payload.reply_byte);
                  errs++;
               end
               if (rsp_payload.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                         rsp_payload.last_of_run);
                  errs++;
               end
               if (rsp_payload.outcome !== want.outcome) begin
                  $error("outcome: expected %0d, got %0d", want.outcome, rsp_payload.outcome);
                  errs++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            negotiate(req_payload);
            accepted_items <= accepted_items + 1;
         end
         fail_count <= fail_count + errs;
      end
      pending_results <= expected_replies.size();
   end

endmodule

/* tb/socks5_method_and_userpass_auth_unit_tb.sv */
// Testbench top for socks5_method_and_userpass_auth_unit: clock, reset, register
// writes and client byte streams with random idling; verdict from socks5_auth_checker.
// Depends on s5auth_pkg, the unit and the checker.
module socks5_method_and_userpass_auth_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import s5auth_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_payload;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [5:0]   paddr;
   logic [63:0]  pwdata;
   logic [63:0]  prdata;
   logic         pready;
   int           fail_count;
   int           pending_results;
   int           accepted_items;

   // no idling on either side while set
   bit           quiet;

   // settings currently in the unit, used to build sessions that get through
   logic         cfg_auth;
   logic [63:0]  cfg_user;
   logic [3:0]   cfg_ulen;
   logic [63:0]  cfg_pass;
   logic [3:0]   cfg_plen;

   socks5_method_and_userpass_auth_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   socks5_auth_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .accepted_items  (accepted_items)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run guard
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stall before each item, none while quiet
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 11);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // One client byte; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic ns);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{rx_byte: b, new_session: ns};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // mixed: new_session mostly on the first byte, now and then elsewhere or missing
   task automatic send_session(input logic [7:0] seq[$], input bit mixed);
      logic ns;
      foreach (seq[i]) begin
         if (!mixed) ns = (i == 0);
         else if (i == 0) ns = ($urandom_range(0, 9) != 0);
         else ns = ($urandom_range(0, 49) == 0);
         send_byte(seq[i], ns);
      end
   endtask

   // Hold off until every reply is in, then wait out swallowed bytes
   task automatic pause_idle();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic auth, input logic [63:0] user,
                                 input logic [3:0] ulen, input logic [63:0] pass,
                                 input logic [3:0] plen);
      pause_idle();
      write_reg(REG_AUTH_REQUIRED, {63'd0, auth});
      write_reg(REG_USER_NAME_BYTES, user);
      write_reg(REG_USER_NAME_LENGTH, {60'd0, ulen});
      write_reg(REG_PASS_WORD_BYTES, pass);
      write_reg(REG_PASS_WORD_LENGTH, {60'd0, plen});
      cfg_auth = auth;
      cfg_user = user;
      cfg_ulen = ulen;
      cfg_pass = pass;
      cfg_plen = plen;
   endtask

   function automatic logic [63:0] rand_cred();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly legal lengths, sometimes 0 or beyond the store
   function automatic logic [3:0] rand_len();
      int v;
      if ($urandom_range(0, 99) < 85) return 4'($urandom_range(1, 8));
      v = $urandom_range(9, 16);
      return (v == 16) ? 4'd0 : 4'(v);
   endfunction

   function automatic logic [7:0] bad_byte(input logic [7:0] good);
      logic [7:0] v;
      v = 8'($urandom);
      return (v == good) ? ~good : v;
   endfunction

   function automatic logic [7:0] pick_method();
      case ($urandom_range(0, 5))
         0:       return METHOD_NONE;
         1:       return METHOD_PASSWORD;
         2:       return METHOD_REFUSED;
         3:       return 8'h01;
         default: return 8'($urandom);
      endcase
   endfunction

   // Field length a client sends: mostly the configured one
   function automatic int field_len(input logic [3:0] cfg_len);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return (cfg_len >= 1 && cfg_len <= 8) ? int'(cfg_len) : $urandom_range(1, 12);
      if (r < 98) return $urandom_range(1, 12);
      return $urandom_range(13, 255);
   endfunction

   // Credential bytes, one of them spoilt now and then
   task automatic add_field(inout logic [7:0] seq[$], input logic [63:0] cred, input int len);
      int spoil;
      logic [7:0] v;
      spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
         v = (i < 8) ? cred[8*i +: 8] : 8'($urandom);
         if (i == spoil) v = v ^ 8'($urandom_range(1, 255));
         seq.push_back(v);
      end
   endtask

   // One random client session: well formed, broken, or plain noise
   task automatic run_session();
      logic [7:0] seq[$];
      logic [7:0] wanted;
      logic [7:0] m;
      int kind;
      int brk;
      int n;
      int r;
      int pos;
      int len;
      bit offered;
      kind = $urandom_range(0, 99);
      wanted = cfg_auth ? METHOD_PASSWORD : METHOD_NONE;
      if (kind >= 90) begin
         repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom));
         send_session(seq, 1'b1);
         return;
      end
      // 0 version, 1 count, 2 auth version, 3 name length, 4 password length, 5 cut short
      brk = (kind >= 70) ? $urandom_range(0, 5) : 6;
      if (!cfg_auth && (brk == 2 || brk == 3 || brk == 4)) brk = 5;

      // greeting
      r = $urandom_range(0, 99);
      n = (r < 85) ? $urandom_range(1, 5) : (r < 97) ? $urandom_range(6, 20)
                                                     : $urandom_range(21, 255);
      seq.push_back((brk == 0) ? bad_byte(PROTO_V5) : PROTO_V5);
      seq.push_back((brk == 1) ? 8'd0 : 8'(n));
      offered = ($urandom_range(0, 99) < 65);
      pos = offered ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
         m = (i == pos) ? wanted : pick_method();
         if (!offered && m == wanted) m = 8'h03;
         seq.push_back(m);
      end

      // user/password subnegotiation
      if (cfg_auth && (offered || $urandom_range(0, 9) == 0)) begin
         seq.push_back((brk == 2) ? bad_byte(AUTH_VER) : AUTH_VER);
         len = field_len(cfg_ulen);
         seq.push_back((brk == 3) ? 8'd0 : 8'(len));
         add_field(seq, cfg_user, len);
         len = field_len(cfg_plen);
         seq.push_back((brk == 4) ? 8'd0 : 8'(len));
         add_field(seq, cfg_pass, len);
      end

      if (brk == 5) begin
         len = $urandom_range(1, seq.size());
         while (seq.size() > len) void'(seq.pop_back());
      end
      // bytes after the end of the session
      if ($urandom_range(0, 99) < 15)
         repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
      send_session(seq, 1'b1);
   endtask

   initial begin
      int next_change;
      int round;
      int waited;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      quiet       = 1'b0;
      cfg_auth    = 1'b0;
      cfg_user    = '0;
      cfg_ulen    = 4'd1;
      cfg_pass    = '0;
      cfg_plen    = 4'd1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: defaults, no authentication wanted
      send_session({PROTO_V5, 8'd1, METHOD_NONE}, 1'b0);
      send_session({8'h04}, 1'b0);
      send_byte(PROTO_V5, 1'b0);             // swallowed: session already over
      send_session({PROTO_V5, 8'd0}, 1'b0);
      send_session({PROTO_V5, 8'd1, METHOD_REFUSED}, 1'b0);
      // Directed: user/password with all-ones name and a zero byte password
      apply_settings(1'b1, '1, 4'd1, '0, 4'd1);
      send_session({PROTO_V5, 8'd1, METHOD_PASSWORD, AUTH_VER, 8'd1, 8'hFF, 8'd1, 8'h00},
                   1'b0);
      send_session({PROTO_V5, 8'd1, METHOD_PASSWORD, AUTH_VER, 8'd0}, 1'b0);

      // Random sessions over several settings
      apply_settings(1'b1, '1, 4'd8, {$urandom, $urandom}, 4'd8);
      next_change = accepted_items + 150;
      round = 0;
      while (accepted_items < 740) begin
         if (accepted_items >= next_change) begin
            round++;
            quiet = 1'b0;
            if (round == 1) apply_settings(1'b1, {$urandom, $urandom}, 4'd15, '0, 4'd0);
            else if (round == 2) apply_settings(1'b0, rand_cred(), rand_len(),
                                                rand_cred(), rand_len());
            else apply_settings(1'($urandom_range(0, 1)), rand_cred(), rand_len(),
                                rand_cred(), rand_len());
            next_change = accepted_items + 150;
         end else if ($urandom_range(0, 19) == 0) begin
            pause_idle();
         end
         quiet = ($urandom_range(0, 4) == 0);
         run_session();
      end

      // Drain
      req_valid <= 1'b0;
      quiet = 1'b0;
      waited = 0;
      while (pending_results != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (pending_results != 0) $error("%0d results never arrived", pending_results);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/s5auth_pkg.sv
src/socks5_method_and_userpass_auth_unit.sv
tb/socks5_auth_checker.sv
tb/socks5_method_and_userpass_auth_unit_tb.sv
